>>> rtl/core/thermistor_poly_median_filter_unit_defines.svh
// assertion macros for the thermistor polynomial median filter
// expects aclk and aresetn in the scope of each use
`ifndef THERMISTOR_POLY_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define THERMISTOR_POLY_MEDIAN_FILTER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define TPMF_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// same-cycle implication
`define TPMF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tpmf_pkg.sv
// types, register indexes, reset values and fixed-point constants
// for the thermistor polynomial median filter; no dependencies
package tpmf_pkg;

    localparam int ADC_BITS        = 12;
    localparam int TEMP_BITS       = 18;
    localparam int WINDOW_SIZE_DEF = 5;
    localparam int FIELD_W         = TEMP_BITS - 1;
    localparam int FRAC_BITS       = 14;
    localparam int REG_IDX_W       = 3;
    localparam int COEF_NUM        = 5;
    localparam int COEF_IDX_W      = $clog2(COEF_NUM);

    // sample to volts: round(s * 3.3 * 2^14 / fullscale) = s * VOLT_INT + frac part
    localparam int ADC_FS      = 2 ** ADC_BITS - 1;
    localparam int VOLT_NUM    = 33 * (2 ** FRAC_BITS);
    localparam int VOLT_DEN    = 10 * ADC_FS;
    localparam int VOLT_INT    = VOLT_NUM / VOLT_DEN;
    localparam int VOLT_REM    = VOLT_NUM % VOLT_DEN;
    localparam int VOLT_HALF   = VOLT_DEN / 2;
    localparam int NUM_MAX     = ADC_FS * VOLT_REM + VOLT_HALF;
    localparam int NUM_W       = $clog2(NUM_MAX + 1);
    localparam int RECIP_SHIFT = NUM_W;
    localparam int RECIP       = (2 ** RECIP_SHIFT) / VOLT_DEN;
    localparam int QUO_W       = $clog2(NUM_MAX / VOLT_DEN + 2);
    localparam int VOLT_W      = $clog2(VOLT_NUM / 10 + 2);

    // horner accumulator and shared multiplier widths
    localparam int ACC_W      = 25;
    localparam int MUL_A_W    = ((NUM_W > ACC_W) ? NUM_W : ACC_W) + 1;
    localparam int MUL_B_W    = VOLT_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    localparam acc_t SAT_HI = acc_t'(2 ** (TEMP_BITS - 2) - 1);
    localparam acc_t SAT_LO = acc_t'(-(2 ** (TEMP_BITS - 2)));

    localparam field_t COEF_C0_RST     = 17'sd34368;
    localparam field_t COEF_C1_RST     = -17'sd40051;
    localparam field_t COEF_C2_RST     = 17'sd27044;
    localparam field_t COEF_C3_RST     = -17'sd10450;
    localparam field_t COEF_C4_RST     = 17'sd1544;
    localparam field_t VALID_MIN_RST   = 17'sd2560;
    localparam field_t VALID_MAX_RST   = 17'sd12800;
    localparam field_t ALARM_LEVEL_RST = 17'sd12800;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_C0,
        REG_COEF_C1,
        REG_COEF_C2,
        REG_COEF_C3,
        REG_COEF_C4,
        REG_VALID_MIN,
        REG_VALID_MAX,
        REG_ALARM_LEVEL
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VSCALE,
        ST_VSUM,
        ST_VRECIP,
        ST_VCHECK,
        ST_VFIX,
        ST_HMUL,
        ST_HACC,
        ST_SAT,
        ST_MEDIAN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/thermistor_poly_median_filter_unit.sv
// thermistor linearization by horner polynomial and median-of-window filter
// uses tpmf_pkg and the assertion macros of thermistor_poly_median_filter_unit_defines.svh
//
//  port group | direction | handshake        | payload
//  cfg        | in        | cfg_wr_en        | cfg_index, cfg_data
//  s          | in        | s_valid, s_ready | s_adc_sample
//  m          | out       | m_valid, m_ready | raw, median, filtered temp, accepted, alarm
//
// one shared signed multiplier with a registered product does all products:
// 3 for the volts conversion, 4 horner steps (multiply, then round and add)
// an item runs volts conversion, horner steps, saturation and median search in turn;
// the median search tries 1..WINDOW_SIZE candidates; a new sample is taken once the result is registered
// result waits in an output register; a new sample is taken meanwhile
// synchronous active-low reset clears control, fill count and held value and loads config reset values
`include "thermistor_poly_median_filter_unit_defines.svh"

module thermistor_poly_median_filter_unit
    import tpmf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADC_BITS-1:0]  s_adc_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [FIELD_W-1:0] m_raw_temp,
    output logic signed [FIELD_W-1:0] m_median_temp,
    output logic signed [FIELD_W-1:0] m_filtered_temp,
    output logic                 m_accepted,
    output logic                 m_alarm
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    state_t state_reg, state_next;

    field_t coef_reg [COEF_NUM];
    field_t coef_next [COEF_NUM];
    field_t vmin_reg, vmin_next;
    field_t vmax_reg, vmax_next;
    field_t alarm_lvl_reg, alarm_lvl_next;

    logic [ADC_BITS-1:0]       sample_reg, sample_next;
    logic signed [MUL_P_W-1:0] prod_reg, prod_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [VOLT_W-1:0]         volt_reg, volt_next;
    acc_t                      acc_reg, acc_next;
    logic [COEF_IDX_W-1:0]     k_reg, k_next;
    field_t                    raw_reg, raw_next;
    field_t                    hist_reg [WINDOW_SIZE];
    field_t                    hist_next [WINDOW_SIZE];
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [IDX_W-1:0]          cand_reg, cand_next;
    field_t                    med_reg, med_next;
    field_t                    held_reg, held_next;

    logic   m_valid_reg, m_valid_next;
    field_t m_raw_reg, m_raw_next;
    field_t m_med_reg, m_med_next;
    field_t m_filt_reg, m_filt_next;
    logic   m_acc_reg, m_acc_next;
    logic   m_alarm_reg, m_alarm_next;

    // shared multiplier operands and helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [QUO_W-1:0]          quo_now;
    logic [NUM_W-1:0]          rem;
    logic                      rem_fix;
    logic signed [MUL_P_W-1:0] rnd;
    field_t                    sat_val;
    field_t                    cand_val;
    logic [CNT_W-1:0]          lt_cnt;
    logic [CNT_W-1:0]          le_cnt;
    logic [CNT_W-1:0]          mid;
    logic                      in_range;
    field_t                    held_new;

    assign quo_now = prod_reg[RECIP_SHIFT +: QUO_W];
    assign rem     = num_reg - prod_reg[NUM_W-1:0];
    assign rem_fix = (rem >= NUM_W'(VOLT_DEN));
    assign rnd     = (prod_reg + MUL_P_W'(ROUND_HALF)) >>> FRAC_BITS;
    assign mid     = fill_reg >> 1;
    assign cand_val = hist_reg[cand_reg];
    assign in_range = (med_reg >= vmin_reg) && (med_reg <= vmax_reg);
    assign held_new = in_range ? med_reg : held_reg;

    always_comb begin
        priority if (acc_reg > SAT_HI) begin
            sat_val = FIELD_W'(SAT_HI);
        end else if (acc_reg < SAT_LO) begin
            sat_val = FIELD_W'(SAT_LO);
        end else begin
            sat_val = FIELD_W'(acc_reg);
        end
    end

    // rank of the current candidate among the filled entries
    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (CNT_W'(j) < fill_reg) begin
                lt_cnt = lt_cnt + CNT_W'(hist_reg[j] < cand_val);
                le_cnt = le_cnt + CNT_W'(hist_reg[j] <= cand_val);
            end
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_VSCALE: begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = MUL_B_W'(VOLT_REM);
            end
            ST_VRECIP: begin
                mul_a = MUL_A_W'(num_reg);
                mul_b = MUL_B_W'(RECIP);
            end
            ST_VCHECK: begin
                mul_a = MUL_A_W'(VOLT_DEN);
                mul_b = MUL_B_W'(quo_now);
            end
            ST_HMUL: begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(volt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // sequencer: next state and next register values
    always_comb begin
        state_next     = state_reg;
        coef_next      = coef_reg;
        vmin_next      = vmin_reg;
        vmax_next      = vmax_reg;
        alarm_lvl_next = alarm_lvl_reg;
        sample_next    = sample_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        volt_next      = volt_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        raw_next       = raw_reg;
        hist_next      = hist_reg;
        fill_next      = fill_reg;
        cand_next      = cand_reg;
        med_next       = med_reg;
        held_next      = held_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_raw_next     = m_raw_reg;
        m_med_next     = m_med_reg;
        m_filt_next    = m_filt_reg;
        m_acc_next     = m_acc_reg;
        m_alarm_next   = m_alarm_reg;
        s_ready        = 1'b0;

        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_C0:     coef_next[0]   = cfg_data;
                REG_COEF_C1:     coef_next[1]   = cfg_data;
                REG_COEF_C2:     coef_next[2]   = cfg_data;
                REG_COEF_C3:     coef_next[3]   = cfg_data;
                REG_COEF_C4:     coef_next[4]   = cfg_data;
                REG_VALID_MIN:   vmin_next      = cfg_data;
                REG_VALID_MAX:   vmax_next      = cfg_data;
                REG_ALARM_LEVEL: alarm_lvl_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sample_next = s_adc_sample;
                    state_next  = ST_VSCALE;
                end
            end
            ST_VSCALE: begin
                state_next = ST_VSUM;
            end
            ST_VSUM: begin
                num_next   = prod_reg[NUM_W-1:0] + NUM_W'(VOLT_HALF);
                state_next = ST_VRECIP;
            end
            ST_VRECIP: begin
                state_next = ST_VCHECK;
            end
            ST_VCHECK: begin
                quo_next   = quo_now;
                state_next = ST_VFIX;
            end
            ST_VFIX: begin
                // quotient estimate is low by at most one
                volt_next = VOLT_W'(VOLT_W'(sample_reg) * VOLT_W'(VOLT_INT))
                          + VOLT_W'(quo_reg) + VOLT_W'(rem_fix);
                acc_next   = ACC_W'(coef_reg[COEF_NUM-1]);
                k_next     = COEF_IDX_W'(COEF_NUM - 2);
                state_next = ST_HMUL;
            end
            ST_HMUL: begin
                state_next = ST_HACC;
            end
            ST_HACC: begin
                acc_next = ACC_W'(rnd) + ACC_W'(coef_reg[k_reg]);
                if (k_reg == '0) begin
                    state_next = ST_SAT;
                end else begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_HMUL;
                end
            end
            ST_SAT: begin
                raw_next = sat_val;
                for (int i = WINDOW_SIZE - 1; i > 0; i--) begin
                    hist_next[i] = hist_reg[i-1];
                end
                hist_next[0] = sat_val;
                if (fill_reg < CNT_W'(WINDOW_SIZE)) begin
                    fill_next = fill_reg + 1'b1;
                end
                cand_next  = '0;
                state_next = ST_MEDIAN;
            end
            ST_MEDIAN: begin
                if ((lt_cnt <= mid) && (le_cnt > mid)) begin
                    med_next   = cand_val;
                    state_next = ST_DONE;
                end else begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    held_next    = held_new;
                    m_valid_next = 1'b1;
                    m_raw_next   = raw_reg;
                    m_med_next   = med_reg;
                    m_filt_next  = held_new;
                    m_acc_next   = in_range;
                    m_alarm_next = (held_new >= alarm_lvl_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            coef_reg[0]   <= COEF_C0_RST;
            coef_reg[1]   <= COEF_C1_RST;
            coef_reg[2]   <= COEF_C2_RST;
            coef_reg[3]   <= COEF_C3_RST;
            coef_reg[4]   <= COEF_C4_RST;
            vmin_reg      <= VALID_MIN_RST;
            vmax_reg      <= VALID_MAX_RST;
            alarm_lvl_reg <= ALARM_LEVEL_RST;
            fill_reg      <= '0;
            held_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            coef_reg      <= coef_next;
            vmin_reg      <= vmin_next;
            vmax_reg      <= vmax_next;
            alarm_lvl_reg <= alarm_lvl_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        volt_reg    <= volt_next;
        acc_reg     <= acc_next;
        k_reg       <= k_next;
        raw_reg     <= raw_next;
        hist_reg    <= hist_next;
        cand_reg    <= cand_next;
        med_reg     <= med_next;
        m_raw_reg   <= m_raw_next;
        m_med_reg   <= m_med_next;
        m_filt_reg  <= m_filt_next;
        m_acc_reg   <= m_acc_next;
        m_alarm_reg <= m_alarm_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_raw_temp      = m_raw_reg;
    assign m_median_temp   = m_med_reg;
    assign m_filtered_temp = m_filt_reg;
    assign m_accepted      = m_acc_reg;
    assign m_alarm         = m_alarm_reg;

    `TPMF_ASSERT_HOLDS(a_fill_bound, fill_reg <= CNT_W'(WINDOW_SIZE), "fill count above window")
    `TPMF_ASSERT_IMPLIES(a_cand_in_fill, state_reg == ST_MEDIAN, (fill_reg != '0) && (CNT_W'(cand_reg) < fill_reg), "median search ran past filled entries")
    `TPMF_ASSERT_IMPLIES(a_accept_takes_median, m_valid && m_accepted, m_filtered_temp == m_median_temp, "accepted median not held")
    `TPMF_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready, "ready after input transfer")

endmodule
